@@ rtl/core/hufd_pkg.sv @@
package hufd_pkg;

   localparam int CODE_BITS = 8;
   localparam int CNT_W     = 4;
   localparam int SYM_W     = 8;
   localparam int MAP_AW    = CODE_BITS + 1;
   localparam int MAP_DEPTH = 1 << MAP_AW;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_DATA  = 2'd2;

   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [SYM_W:0]    data;
   } map_wr_type;

   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
   } map_rd_type;

endpackage

@@ rtl/core/hufd_map.sv @@
module hufd_map (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear_req,
   input  hufd_pkg::map_wr_type   wr,
   input  hufd_pkg::map_rd_type   rd,
   output logic [hufd_pkg::SYM_W:0] rd_data,
   output logic                   busy
);
   import hufd_pkg::*;

   logic [SYM_W:0]    mem [MAP_DEPTH];
   logic [SYM_W:0]    rdata_ff;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;

   assign rd_data = rdata_ff;
   assign busy    = busy_ff;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in  = clr_ff + 1'b1;
         busy_in = (clr_ff != {MAP_AW{1'b1}});
      end else if (clear_req) begin
         clr_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // valid bit plus symbol per entry; sweep wipes valid bits
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr];
      end
   end

endmodule

@@ rtl/core/huffman_table_decoder.sv @@
// Prefix-code decoder with a loadable table of up to 256 codes of 1 to 8 bits.
// A clear item (and reset) starts a sweep that wipes all 512 entries of the
// code table, during which no item is taken. A load item reads the entry,
// then writes it if it is still empty. A data byte (bits_in_byte capped at 8)
// holds the input until its bits are used up: one code bit is looked up per
// cycle while the output does not stall, since the registered table read of
// one bit selects the address of the next. A byte that yields any result then
// sends out its last result from the flush state, flagged run_last.
module huffman_table_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [7:0]                  req_entry_symbol,
   input  logic [3:0]                  req_entry_length,
   input  logic [7:0]                  req_entry_code,
   input  logic [7:0]                  req_data_byte,
   input  logic [3:0]                  req_bits_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_symbol,
   output logic                        rsp_overflow,
   output logic                        rsp_run_last
);
   import hufd_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_FLUSH} state_type;

   state_type            state_ff, state_in;
   logic [CODE_BITS-1:0] p_bits_ff, p_bits_in;
   logic [CNT_W-1:0]     p_cnt_ff, p_cnt_in;
   logic                 fly_ff, fly_in;
   logic [7:0]           sh_ff, sh_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic                 held_ff, held_in;
   logic [SYM_W-1:0]     held_sym_ff, held_sym_in;
   logic                 held_ovf_ff, held_ovf_in;
   logic [SYM_W-1:0]     wsym_ff, wsym_in;
   logic [MAP_AW-1:0]    waddr_ff, waddr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;
   logic                 rsp_run_last_ff, rsp_run_last_in;

   logic                 req_accept, clear_req, map_busy;
   logic [SYM_W:0]       map_rdata;
   map_wr_type           wr;
   map_rd_type           rd;
   logic                 hit, ovf, new_res, can_push, blocked;
   logic [CODE_BITS-1:0] res_bits, nxt_bits;
   logic [CNT_W-1:0]     res_cnt, nxt_cnt;
   logic [MAP_AW-1:0]    nxt_addr, ent_addr;

   hufd_map u_map (
      .clock     (clock),
      .reset     (reset),
      .clear_req (clear_req),
      .wr        (wr),
      .rd        (rd),
      .rd_data   (map_rdata),
      .busy      (map_busy)
   );

   assign req_stall    = (state_ff != ST_IDLE) | map_busy;
   assign req_accept   = req_valid & ~req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_symbol_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_run_last = rsp_run_last_ff;

   assign ent_addr = (MAP_AW'(1) << req_entry_length)
                   | MAP_AW'(req_entry_code >> (4'd8 - req_entry_length));

   always_comb begin
      hit      = fly_ff & map_rdata[SYM_W];
      ovf      = fly_ff & ~map_rdata[SYM_W] & (p_cnt_ff == CNT_W'(CODE_BITS));
      new_res  = hit | ovf;
      can_push = ~rsp_valid_ff | ~rsp_stall;
      blocked  = new_res & held_ff & ~can_push;
      res_bits = new_res ? '0 : p_bits_ff;
      res_cnt  = new_res ? '0 : p_cnt_ff;
      nxt_bits = {res_bits[CODE_BITS-2:0], sh_ff[7]};
      nxt_cnt  = res_cnt + 1'b1;
      nxt_addr = (MAP_AW'(1) << nxt_cnt) | MAP_AW'(nxt_bits);
   end

   always_comb begin
      state_in        = state_ff;
      p_bits_in       = p_bits_ff;
      p_cnt_in        = p_cnt_ff;
      fly_in          = fly_ff;
      sh_in           = sh_ff;
      left_in         = left_ff;
      held_in         = held_ff;
      held_sym_in     = held_sym_ff;
      held_ovf_in     = held_ovf_ff;
      wsym_in         = wsym_ff;
      waddr_in        = waddr_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_run_last_in = rsp_run_last_ff;
      clear_req       = 1'b0;
      wr              = '0;
      rd              = '0;
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     clear_req = 1'b1;
                     p_bits_in = '0;
                     p_cnt_in  = '0;
                  end
                  FUNC_LOAD: begin
                     if (req_entry_length != '0 &&
                         req_entry_length <= CNT_W'(CODE_BITS)) begin
                        rd.en    = 1'b1;
                        rd.addr  = ent_addr;
                        waddr_in = ent_addr;
                        wsym_in  = req_entry_symbol;
                        state_in = ST_LOAD;
                     end
                  end
                  FUNC_DATA: begin
                     if (req_bits_in_byte != '0) begin
                        sh_in    = req_data_byte;
                        left_in  = (req_bits_in_byte > CNT_W'(CODE_BITS)) ?
                                   CNT_W'(CODE_BITS) : req_bits_in_byte;
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // first symbol loaded for a code wins
            wr.en    = ~map_rdata[SYM_W];
            wr.addr  = waddr_ff;
            wr.data  = {1'b1, wsym_ff};
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            if (!blocked) begin
               if (new_res) begin
                  if (held_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_symbol_in   = held_sym_ff;
                     rsp_overflow_in = held_ovf_ff;
                     rsp_run_last_in = 1'b0;
                  end
                  held_in     = 1'b1;
                  held_sym_in = hit ? map_rdata[SYM_W-1:0] : '0;
                  held_ovf_in = ovf;
               end
               if (left_ff != '0) begin
                  rd.en     = 1'b1;
                  rd.addr   = nxt_addr;
                  p_bits_in = nxt_bits;
                  p_cnt_in  = nxt_cnt;
                  fly_in    = 1'b1;
                  sh_in     = {sh_ff[6:0], 1'b0};
                  left_in   = left_ff - 1'b1;
               end else begin
                  p_bits_in = res_bits;
                  p_cnt_in  = res_cnt;
                  fly_in    = 1'b0;
                  state_in  = (held_ff | new_res) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (can_push) begin
               rsp_valid_in    = 1'b1;
               rsp_symbol_in   = held_sym_ff;
               rsp_overflow_in = held_ovf_ff;
               rsp_run_last_in = 1'b1;
               held_in         = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_bits_ff    <= '0;
         p_cnt_ff     <= '0;
         fly_ff       <= 1'b0;
         left_ff      <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_bits_ff    <= p_bits_in;
         p_cnt_ff     <= p_cnt_in;
         fly_ff       <= fly_in;
         left_ff      <= left_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sh_ff           <= sh_in;
      held_sym_ff     <= held_sym_in;
      held_ovf_ff     <= held_ovf_in;
      wsym_ff         <= wsym_in;
      waddr_ff        <= waddr_in;
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_run_last_ff <= rsp_run_last_in;
   end

`ifndef NO_ASSERTIONS
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      map_busy |-> !wr.en)
      else $error("table write during clearing sweep");

   a_pend_cnt_range: assert property (@(posedge clock) disable iff (reset)
      p_cnt_ff <= CNT_W'(CODE_BITS))
      else $error("pending code longer than table allows");

   a_fly_only_run: assert property (@(posedge clock) disable iff (reset)
      fly_ff |-> state_ff == ST_RUN)
      else $error("lookup in flight outside bit loop");

   a_flush_has_item: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> held_ff)
      else $error("flush without a held item");

   a_load_follows_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> $past(rd.en))
      else $error("entry write without prior table read");
`endif

endmodule
